FILE: rtl/newton_backward_interpolator_assert.svh
// Assertion macros shared by the checker of the backward-difference interpolator.
// No dependencies; the including file supplies clock, reset and signals.
`ifndef NEWTON_BACKWARD_INTERPOLATOR_ASSERT_SVH
`define NEWTON_BACKWARD_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NBI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NBI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nbi_pkg.sv
// Shared types, register codes and constant tables of the interpolator.
// Used by the top level and by its port checker; depends on nothing.
`default_nettype none

package nbi_pkg;

    // Default sizes of the block.
    localparam int NBI_MAX_POINTS  = 32;
    localparam int NBI_MAX_ORDER   = 8;
    localparam int NBI_VALUE_WIDTH = 32;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_GRID_START   = 2'd0;
    localparam logic [1:0] REG_INVERSE_STEP = 2'd1;
    localparam logic [1:0] REG_POINTS       = 2'd2;
    localparam logic [1:0] REG_ORDER        = 2'd3;

    // Request codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Input word.
    typedef struct packed {
        logic               req_type;
        logic [4:0]         sample_index;
        logic signed [31:0] sample_value;
        logic signed [31:0] query_x;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic signed [31:0] interpolated_value;
        logic               value_saturated;
        logic               edge_base_used;
    } t_out_word;

    // floor(2^51 / j) for the divisor j of the coefficient recurrence.
    function automatic logic [52:0] nbi_recip(input logic [3:0] j);
        logic [52:0] r;
        unique case (j)
            4'd1:    r = 53'd2251799813685248;
            4'd2:    r = 53'd1125899906842624;
            4'd3:    r = 53'd750599937895082;
            4'd4:    r = 53'd562949953421312;
            4'd5:    r = 53'd450359962737049;
            4'd6:    r = 53'd375299968947541;
            4'd7:    r = 53'd321685687669321;
            4'd8:    r = 53'd281474976710656;
            4'd9:    r = 53'd250199979298360;
            4'd10:   r = 53'd225179981368524;
            4'd11:   r = 53'd204709073971386;
            4'd12:   r = 53'd187649984473770;
            default: r = 53'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/newton_backward_interpolator.sv
// Newton backward-difference interpolator over a stored grid of Q16.16 samples.
// Depends on nbi_pkg for the word types, register codes and reciprocal table.
//
// A load word writes one sample into the sample memory; the block is ready
// again in the next cycle. A query does one memory read per sample of the
// stencil, then for every term three products on the single shared 53x16
// multiplier, each taking three passes, before the result register is written.
// The block takes no new word while a query is in progress; a finished result
// waits in the output register while the next word is accepted. Results
// saturate to VALUE_WIDTH bits and flag it. The configuration port has four
// 32-bit registers at byte addresses 0, 4, 8 and 12; the user must write it
// only while the block is idle. The block itself does not enforce this.
`default_nettype none

module newton_backward_interpolator #(
    parameter int MAX_POINTS  = nbi_pkg::NBI_MAX_POINTS,
    parameter int MAX_ORDER   = nbi_pkg::NBI_MAX_ORDER,
    parameter int VALUE_WIDTH = nbi_pkg::NBI_VALUE_WIDTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // Input channel.
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  nbi_pkg::t_in_word   i_in_word,
    // Result channel.
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output nbi_pkg::t_out_word  o_out_word,
    // Configuration port.
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import nbi_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int DW = 32 + MAX_ORDER;

    localparam logic [46:0]        ACC_MAX47 = {47{1'b1}};
    localparam logic signed [48:0] ACC_MAX49 = 49'sd140737488355327;
    localparam logic signed [48:0] ACC_MIN49 = -49'sd140737488355327;
    localparam logic signed [47:0] VMAX = (48'sd1 <<< (VALUE_WIDTH - 1)) - 48'sd1;
    localparam logic signed [47:0] VMIN = -VMAX - 48'sd1;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_BASE  = 4'd2;
    localparam logic [3:0] ST_P     = 4'd3;
    localparam logic [3:0] ST_READ  = 4'd4;
    localparam logic [3:0] ST_RLAST = 4'd5;
    localparam logic [3:0] ST_INIT  = 4'd6;
    localparam logic [3:0] ST_TERM  = 4'd7;
    localparam logic [3:0] ST_CDIV  = 4'd8;
    localparam logic [3:0] ST_CCORR = 4'd9;
    localparam logic [3:0] ST_TACC  = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    // Configuration registers.
    logic signed [31:0] r_grid_start;
    logic [31:0]        r_inv_step;
    logic [5:0]         r_points;
    logic [3:0]         r_order;

    // Sequencer and datapath registers.
    logic [3:0]              r_state;
    logic [3:0]              r_ret;
    logic [1:0]              r_mcnt;
    logic [52:0]             r_ma;
    logic [47:0]             r_mb;
    logic [100:0]            r_prod;
    logic                    r_dneg;
    logic signed [49:0]      r_u;
    logic signed [34:0]      r_k;
    logic signed [51:0]      r_p;
    logic                    r_edge;
    logic                    r_sat;
    logic [AW-1:0]           r_raddr;
    logic [OW-1:0]           r_rcnt;
    logic                    r_rvalid;
    logic [31:0]             r_rdata;
    logic signed [DW-1:0]    r_work [0:MAX_ORDER];
    logic [OW-1:0]           r_j;
    logic [47:0]             r_cmag;
    logic                    r_csign;
    logic                    r_csg_n;
    logic [47:0]             r_qm;
    logic                    r_tneg;
    logic signed [47:0]      r_acc;
    logic                    r_ovalid;
    t_out_word               r_out;
    logic [31:0]             r_mem [0:MAX_POINTS-1];

    // Combinational helpers.
    logic               in_acc;
    logic               load_wr;
    logic               rd_en;
    logic [NW-1:0]      n_eff;
    logic [OW-1:0]      ord1;
    logic [OW-1:0]      ord_eff;
    logic signed [34:0] nm1_s;
    logic signed [34:0] ord_s;
    logic signed [32:0] d_s;
    logic [32:0]        d_mag;
    logic [68:0]        part;
    logic [48:0]        um;
    logic [49:0]        um_up;
    logic [AW-1:0]      n_base;
    logic               n_edge;
    logic signed [51:0] pa;
    logic [51:0]        pa_mag;
    logic               p_ovf;
    logic [46:0]        q_sat;
    logic [47:0]        q0;
    logic [51:0]        q0j;
    logic [51:0]        rem;
    logic [47:0]        q_cor;
    logic [DW-1:0]      d_mag_w;
    logic signed [48:0] t_s;
    logic signed [48:0] sum_s;
    logic signed [47:0] res;
    logic               res_clamp;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign load_wr = in_acc && (i_in_word.req_type == REQ_LOAD)
                     && (32'(i_in_word.sample_index) < MAX_POINTS);
    assign rd_en   = (r_state == ST_READ);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;
    assign pready      = 1'b1;

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_GRID_START:   prdata = r_grid_start;
            REG_INVERSE_STEP: prdata = r_inv_step;
            REG_POINTS:       prdata = 32'(r_points);
            REG_ORDER:        prdata = 32'(r_order);
            default:          prdata = 32'd0;
        endcase
    end

    // Effective grid size and order after clamping.
    always_comb begin
        if (r_points < 6'd2) begin
            n_eff = NW'(2);
        end else if (32'(r_points) > MAX_POINTS) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = NW'(r_points);
        end
        if (r_order == 4'd0) begin
            ord1 = OW'(1);
        end else if (32'(r_order) > MAX_ORDER) begin
            ord1 = OW'(MAX_ORDER);
        end else begin
            ord1 = OW'(r_order);
        end
        if (32'(ord1) > 32'(n_eff) - 32'd1) begin
            ord_eff = OW'(n_eff - NW'(1));
        end else begin
            ord_eff = ord1;
        end
        nm1_s = 35'(n_eff) - 35'sd1;
        ord_s = 35'(ord_eff);
    end

    // Offset of the query from the grid start and one multiplier pass.
    always_comb begin
        d_s   = 33'(i_in_word.query_x) - 33'(r_grid_start);
        d_mag = d_s[32] ? 33'(-d_s) : 33'(d_s);
        part  = r_ma * r_mb[47:32];
    end

    // Node index, base node and local coordinate.
    always_comb begin
        um    = r_prod[64:16];
        um_up = 50'(um) + 50'h0FFFF;
        if (r_k > nm1_s) begin
            n_base = AW'(n_eff - NW'(1));
            n_edge = 1'b1;
        end else if (r_k < ord_s) begin
            n_base = AW'(ord_eff);
            n_edge = 1'b1;
        end else begin
            n_base = r_k[AW-1:0];
            n_edge = 1'b0;
        end
        pa     = r_p + 52'({(r_j - OW'(1)), 16'h0000});
        pa_mag = pa[51] ? 52'(-pa) : 52'(pa);
    end

    // Product scaling with overflow clamp, reciprocal correction, accumulation.
    always_comb begin
        p_ovf   = |r_prod[100:63];
        q_sat   = p_ovf ? ACC_MAX47 : r_prod[62:16];
        q0      = r_prod[98:51];
        q0j     = q0 * 4'(r_j);
        rem     = 52'(r_qm) - q0j;
        q_cor   = (rem >= 52'(r_j)) ? q0 + 48'd1 : q0;
        d_mag_w = r_work[MAX_ORDER][DW-1] ? DW'(-r_work[MAX_ORDER])
                                          : DW'(r_work[MAX_ORDER]);
        t_s     = r_tneg ? -49'(q_sat) : 49'(q_sat);
        sum_s   = 49'(r_acc) + t_s;
        if (r_acc > VMAX) begin
            res = VMAX;
            res_clamp = 1'b1;
        end else if (r_acc < VMIN) begin
            res = VMIN;
            res_clamp = 1'b1;
        end else begin
            res = r_acc;
            res_clamp = 1'b0;
        end
    end

    // Sample memory: written by loads, read one node a cycle by queries.
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_mem[AW'(i_in_word.sample_index)] <= i_in_word.sample_value;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_start <= -32'sd655360;
            r_inv_step   <= 32'd65536;
            r_points     <= 6'd21;
            r_order      <= 4'd5;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_GRID_START:   r_grid_start <= pwdata;
                REG_INVERSE_STEP: r_inv_step   <= pwdata;
                REG_POINTS:       r_points     <= pwdata[5:0];
                REG_ORDER:        r_order      <= pwdata[3:0];
                default:          r_order      <= r_order;
            endcase
        end
    end

    // Stencil window: shifts in read samples, then forms one difference level.
    always_ff @(posedge i_clk) begin
        if (r_rvalid) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_work[i] <= r_work[i + 1];
            end
            r_work[MAX_ORDER] <= DW'($signed(r_rdata));
        end else if (r_state == ST_TERM) begin
            for (int i = 1; i <= MAX_ORDER; i++) begin
                r_work[i] <= r_work[i] - r_work[i - 1];
            end
        end
    end

    // Read-valid flag is the registered read enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= rd_en;
        end
    end

    // Sequencer with the shared multiplier.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // A taken result word leaves the register, unless a new one replaces it.
            if (r_ovalid && !i_out_stall && (r_state != ST_FIN)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in_word.req_type == REQ_QUERY)) begin
                        r_dneg  <= d_s[32];
                        r_ma    <= 53'(r_inv_step);
                        r_mb    <= 48'(d_mag);
                        r_prod  <= '0;
                        r_mcnt  <= 2'd0;
                        r_ret   <= ST_BASE;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod <= {r_prod[84:0], 16'h0000} + 101'(part);
                    r_mb   <= {r_mb[31:0], 16'h0000};
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd2) begin
                        r_state <= r_ret;
                    end
                end
                ST_BASE: begin
                    r_u <= r_dneg ? -50'(um) : 50'(um);
                    if (!r_dneg && (um != 49'd0)) begin
                        r_k <= 35'(um_up[49:16]);
                    end else begin
                        r_k <= -35'(um[48:16]);
                    end
                    r_state <= ST_P;
                end
                ST_P: begin
                    r_edge  <= n_edge;
                    r_p     <= 52'(r_u) - 52'({n_base, 16'h0000});
                    r_raddr <= n_base - AW'(ord_eff);
                    r_rcnt  <= '0;
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_raddr <= r_raddr + AW'(1);
                    r_rcnt  <= r_rcnt + OW'(1);
                    if (r_rcnt == ord_eff) begin
                        r_state <= ST_RLAST;
                    end
                end
                ST_RLAST: begin
                    r_state <= ST_INIT;
                end
                ST_INIT: begin
                    r_acc   <= 48'(r_work[MAX_ORDER]);
                    r_cmag  <= 48'd65536;
                    r_csign <= 1'b0;
                    r_sat   <= 1'b0;
                    r_j     <= OW'(1);
                    r_state <= ST_TERM;
                end
                ST_TERM: begin
                    // Coefficient product c * (p + j - 1).
                    r_ma    <= 53'(pa_mag);
                    r_mb    <= r_cmag;
                    r_csg_n <= r_csign ^ pa[51];
                    r_prod  <= '0;
                    r_mcnt  <= 2'd0;
                    r_ret   <= ST_CDIV;
                    r_state <= ST_MUL;
                end
                ST_CDIV: begin
                    // Divide the magnitude by j through its reciprocal.
                    r_qm    <= 48'(q_sat);
                    r_sat   <= r_sat | p_ovf;
                    r_ma    <= nbi_recip(4'(r_j));
                    r_mb    <= 48'(q_sat);
                    r_prod  <= '0;
                    r_mcnt  <= 2'd0;
                    r_ret   <= ST_CCORR;
                    r_state <= ST_MUL;
                end
                ST_CCORR: begin
                    // Correct the quotient, then start the term product.
                    r_cmag  <= q_cor;
                    r_csign <= r_csg_n;
                    r_ma    <= 53'(d_mag_w);
                    r_mb    <= q_cor;
                    r_tneg  <= r_work[MAX_ORDER][DW-1] ^ r_csg_n;
                    r_prod  <= '0;
                    r_mcnt  <= 2'd0;
                    r_ret   <= ST_TACC;
                    r_state <= ST_MUL;
                end
                ST_TACC: begin
                    if (sum_s > ACC_MAX49) begin
                        r_acc <= 48'(ACC_MAX49);
                        r_sat <= 1'b1;
                    end else if (sum_s < ACC_MIN49) begin
                        r_acc <= 48'(ACC_MIN49);
                        r_sat <= 1'b1;
                    end else begin
                        r_acc <= 48'(sum_s);
                        r_sat <= r_sat | p_ovf;
                    end
                    if (r_j == ord_eff) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_j     <= r_j + OW'(1);
                        r_state <= ST_TERM;
                    end
                end
                ST_FIN: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out.interpolated_value <= res[31:0];
                        r_out.value_saturated    <= r_sat | res_clamp;
                        r_out.edge_base_used     <= r_edge;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nbi_checker.sv
// Port-level checker of the interpolator and its bind to the top level.
// Depends on nbi_pkg and on the assertion macros header.
`default_nettype none
`include "newton_backward_interpolator_assert.svh"

module nbi_port_assertions (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input nbi_pkg::t_in_word   i_in_word,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input nbi_pkg::t_out_word  o_out_word
);
    import nbi_pkg::*;

    logic query_acc;
    logic load_acc;

    assign query_acc = i_in_valid && !o_in_stall && (i_in_word.req_type == REQ_QUERY);
    assign load_acc  = i_in_valid && !o_in_stall && (i_in_word.req_type == REQ_LOAD);

    // A stalled result word stays valid and unchanged.
    `NBI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result word dropped while stalled")
    `NBI_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_word), "result word changed while stalled")

    // A query occupies the block; a load leaves it ready.
    `NBI_ASSERT_NXT(a_query_busy, i_clk, i_rst_n, query_acc, o_in_stall, "query accepted without going busy")
    `NBI_ASSERT_NXT(a_load_quick, i_clk, i_rst_n, load_acc, !o_in_stall, "load kept the block busy")

    // A new result only ever closes a query in progress.
    `NBI_ASSERT_IMP(a_out_from_query, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without a query in progress")

endmodule

bind newton_backward_interpolator nbi_port_assertions u_nbi_port_assertions (.*);

`default_nettype wire
